// ----- rtl/text_console_writer_defines.svh -----
// assertion macros for the checker file
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TCW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcw check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcw check failed");

`endif

// ----- rtl/tcw_pkg.sv -----
`default_nettype none

package tcw_pkg;

    // screen store geometry
    localparam int MAX_COLS    = 128;
    localparam int MAX_ROWS    = 32;
    localparam int STORE_CELLS = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W      = $clog2(STORE_CELLS);
    localparam int PTR_W       = ADDR_W + 1;
    localparam int COLS_W      = 8;
    localparam int ROWS_W      = 6;
    localparam int CFG_IDX_W   = 2;

    // command codes
    localparam logic [2:0] FN_PUT    = 3'd0;
    localparam logic [2:0] FN_CURSOR = 3'd1;
    localparam logic [2:0] FN_CLEAR  = 3'd2;
    localparam logic [2:0] FN_COLOUR = 3'd3;
    localparam logic [2:0] FN_READ   = 3'd4;

    // special characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;

    // reset values
    localparam logic [COLS_W-1:0] RESET_COLS = 8'd80;
    localparam logic [ROWS_W-1:0] RESET_ROWS = 6'd25;
    localparam logic [3:0]        RESET_FG   = 4'h7;
    localparam logic [3:0]        RESET_BG   = 4'h0;
    localparam logic [15:0]       INIT_CELL  = 16'h0700;

    typedef struct packed {
        logic                 wen;
        logic [CFG_IDX_W-1:0] index;
        logic [COLS_W-1:0]    data;
    } cfg_wr_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] char_code;
        logic [6:0] pos_x;
        logic [4:0] pos_y;
        logic [3:0] fg_in;
        logic [3:0] bg_in;
    } cmd_t;

    typedef struct packed {
        logic [6:0]  cursor_x;
        logic [4:0]  cursor_y;
        logic [11:0] cursor_offset;
        logic [3:0]  fg_out;
        logic [3:0]  bg_out;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } res_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       data;
    } cell_wr_t;

    typedef struct packed {
        logic [PTR_W-1:0]  add;
        logic [ROWS_W-1:0] mul_a;
        logic [COLS_W-1:0] mul_b;
    } mac_req_t;

    // zero reads as one, large values saturate
    function automatic logic [COLS_W-1:0] clamp_cols(input logic [COLS_W-1:0] v);
        logic [COLS_W-1:0] r;
        if (v == '0)
            r = COLS_W'(1);
        else if (v > COLS_W'(MAX_COLS))
            r = COLS_W'(MAX_COLS);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [ROWS_W-1:0] clamp_rows(input logic [ROWS_W-1:0] v);
        logic [ROWS_W-1:0] r;
        if (v == '0)
            r = ROWS_W'(1);
        else if (v > ROWS_W'(MAX_ROWS))
            r = ROWS_W'(MAX_ROWS);
        else
            r = v;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/text_console_writer.sv -----
// channel  | dir | handshake         | payload
// ---------+-----+-------------------+------------------------------------------
// command  | in  | s_tvalid/s_tready | s_tuser func, s_tdata char/pos/colours
// result   | out | m_tvalid/m_tready | m_tdata cursor, offset, colours, cell
// config   | in  | cfg_wen           | cfg_index, cfg_wdata (cols, rows)
//
// after reset the cell store is swept to 0x0700 with s_tready low
// accept to m_tvalid: cursor, colours, null and unused codes go straight to the offset;
// newline wraps first, backspace and read touch one cell, characters and tabs write cells,
// clear blanks the whole screen; one command at a time; a scroll moves each cell with a
// read then a write through the single store port pair; offsets come from one shared multiply-add
// the output register holds one result, so a stalled m_tready only blocks the next one
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,   // char_code, pos_x, pos_y, fg_in, bg_in
    input  wire logic [2:0]           s_tuser,   // func
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [47:0]               m_tdata,   // cursor_x, cursor_y, cursor_offset,
                                                 // fg_out, bg_out, cell_char, cell_attr
    input  wire logic                 cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COLS_W-1:0]    cfg_wdata
);

    cfg_wr_t           cfg;
    cmd_t              cmd;
    res_t              res;
    logic              res_valid;
    logic              res_ready;
    mac_req_t          mac_req;
    logic [PTR_W-1:0]  mac_res;
    cell_wr_t          cell_wr;
    logic [ADDR_W-1:0] cell_raddr;
    logic [15:0]       cell_rdata;
    logic              out_valid_reg;
    res_t              out_data_reg;

    // unpack the command beat
    assign cfg = '{wen: cfg_wen, index: cfg_index, data: cfg_wdata};
    assign cmd = '{
        func:      s_tuser,
        char_code: s_tdata[7:0],
        pos_x:     s_tdata[14:8],
        pos_y:     s_tdata[19:15],
        fg_in:     s_tdata[23:20],
        bg_in:     s_tdata[27:24]
    };

    tcw_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd_valid  (s_tvalid),
        .cmd        (cmd),
        .cmd_ready  (s_tready),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready),
        .mac_req    (mac_req),
        .mac_res    (mac_res),
        .cell_wr    (cell_wr),
        .cell_raddr (cell_raddr),
        .cell_rdata (cell_rdata)
    );

    tcw_mac u_mac (
        .clk (clk),
        .req (mac_req),
        .res (mac_res)
    );

    tcw_cell_mem u_mem (
        .clk   (clk),
        .wr    (cell_wr),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    // output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    // pack the result beat, first field lowest
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.cell_attr, out_data_reg.cell_char,
                       out_data_reg.bg_out, out_data_reg.fg_out,
                       out_data_reg.cursor_offset, out_data_reg.cursor_y,
                       out_data_reg.cursor_x};

endmodule

`default_nettype wire

// ----- rtl/tcw_mac.sv -----
`default_nettype none

// shared multiply-add: res = add + mul_a * mul_b, registered
module tcw_mac
    import tcw_pkg::*;
(
    input  wire logic             clk,
    input  wire mac_req_t         req,
    output logic [PTR_W-1:0]      res
);

    logic [ROWS_W+COLS_W-1:0] prod;
    logic [PTR_W:0]           sum;
    logic [PTR_W-1:0]         res_reg;

    assign prod = req.mul_a * req.mul_b;
    assign sum  = {1'b0, req.add} + (PTR_W+1)'(prod);

    // result register
    always_ff @(posedge clk)
    begin
        res_reg <= sum[PTR_W-1:0];
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ----- rtl/tcw_cell_mem.sv -----
`default_nettype none

// character cell store, one write and one registered read per cycle
module tcw_cell_mem
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire cell_wr_t          wr,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic [15:0]            rdata
);

    logic [15:0] mem_array [STORE_CELLS];
    logic [15:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_array[wr.addr] <= wr.data;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_array[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/tcw_seq.sv -----
`default_nettype none

// command sequencer: cursor, colours, geometry and cell walks
module tcw_seq
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_wr_t           cfg,
    input  wire logic              cmd_valid,
    input  wire cmd_t              cmd,
    output logic                   cmd_ready,
    output logic                   res_valid,
    output res_t                   res,
    input  wire logic              res_ready,
    output mac_req_t               mac_req,
    input  wire logic [PTR_W-1:0]  mac_res,
    output cell_wr_t               cell_wr,
    output logic [ADDR_W-1:0]      cell_raddr,
    input  wire logic [15:0]       cell_rdata
);

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_BASE,
        S_PTR,
        S_TAB_LIM,
        S_TAB,
        S_PUT,
        S_WRAP,
        S_SCR_LIM,
        S_SCR_LIM2,
        S_SCR_RD,
        S_SCR_WR,
        S_CLR_LIM,
        S_CLR_LIM2,
        S_FILL,
        S_RD_ADDR,
        S_RD_MEM,
        S_RD_DATA,
        S_OFFSET,
        S_DONE
    } state_t;

    state_t            state_reg,  state_next;
    logic [COLS_W-1:0] col_reg,    col_next;
    logic [ROWS_W-1:0] row_reg,    row_next;
    logic [3:0]        fg_reg,     fg_next;
    logic [3:0]        bg_reg,     bg_next;
    logic [COLS_W-1:0] cols_reg,   cols_next;
    logic [ROWS_W-1:0] rows_reg,   rows_next;
    logic [PTR_W-1:0]  ptr_reg,    ptr_next;
    logic [PTR_W-1:0]  end_reg,    end_next;
    logic [7:0]        ch_reg,     ch_next;
    logic [6:0]        px_reg,     px_next;
    logic [4:0]        py_reg,     py_next;
    logic [7:0]        rc_reg,     rc_next;
    logic [7:0]        ra_reg,     ra_next;

    logic [7:0]        attr;
    logic [ROWS_W-1:0] row_wrap;
    logic [COLS_W-1:0] cols_new;
    logic [ROWS_W-1:0] rows_new;

    assign attr      = {bg_reg, fg_reg};
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    // result fields, offset comes from the shared unit
    assign res = '{
        cursor_x:      col_reg[6:0],
        cursor_y:      row_reg[4:0],
        cursor_offset: mac_res[ADDR_W-1:0],
        fg_out:        fg_reg,
        bg_out:        bg_reg,
        cell_char:     rc_reg,
        cell_attr:     ra_reg
    };

    // next-state logic
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        cols_next  = cols_reg;
        rows_next  = rows_reg;
        ptr_next   = ptr_reg;
        end_next   = end_reg;
        ch_next    = ch_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        rc_next    = rc_reg;
        ra_next    = ra_reg;
        row_wrap   = row_reg;
        cols_new   = clamp_cols(cfg.data);
        rows_new   = clamp_rows(cfg.data[ROWS_W-1:0]);
        mac_req    = '{add: PTR_W'(col_reg), mul_a: row_reg, mul_b: cols_reg};
        cell_wr    = '{en: 1'b0, addr: ptr_reg[ADDR_W-1:0], data: INIT_CELL};
        cell_raddr = ptr_reg[ADDR_W-1:0];

        unique case (state_reg)
            // sweep the whole store to its reset value
            S_INIT:
            begin
                cell_wr  = '{en: 1'b1, addr: ptr_reg[ADDR_W-1:0], data: INIT_CELL};
                ptr_next = ptr_reg + PTR_W'(1);
                if (ptr_reg[ADDR_W-1:0] == '1)
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
            end

            // take a command and decode it
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ch_next = cmd.char_code;
                    px_next = cmd.pos_x;
                    py_next = cmd.pos_y;
                    rc_next = '0;
                    ra_next = '0;
                    unique case (cmd.func)
                        FN_PUT:
                        begin
                            if (cmd.char_code == CH_NUL)
                            begin
                                state_next = S_OFFSET;
                            end
                            else if (cmd.char_code == CH_BS)
                            begin
                                if (col_reg == '0 && row_reg == '0)
                                begin
                                    state_next = S_OFFSET;
                                end
                                else
                                begin
                                    if (col_reg != '0)
                                    begin
                                        col_next = col_reg - COLS_W'(1);
                                    end
                                    else
                                    begin
                                        col_next = cols_reg - COLS_W'(1);
                                        row_next = row_reg - ROWS_W'(1);
                                    end
                                    state_next = S_BASE;
                                end
                            end
                            else if (cmd.char_code == CH_LF)
                            begin
                                col_next   = cols_reg;
                                state_next = S_WRAP;
                            end
                            else
                            begin
                                state_next = S_BASE;
                            end
                        end
                        FN_CURSOR:
                        begin
                            if ({1'b0, cmd.pos_x} < cols_reg)
                            begin
                                col_next = {1'b0, cmd.pos_x};
                            end
                            if ({1'b0, cmd.pos_y} < rows_reg)
                            begin
                                row_next = {1'b0, cmd.pos_y};
                            end
                            state_next = S_OFFSET;
                        end
                        FN_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            state_next = S_CLR_LIM;
                        end
                        FN_COLOUR:
                        begin
                            fg_next    = cmd.fg_in;
                            bg_next    = cmd.bg_in;
                            state_next = S_OFFSET;
                        end
                        FN_READ:
                        begin
                            if ({1'b0, cmd.pos_x} < cols_reg && {1'b0, cmd.pos_y} < rows_reg)
                            begin
                                state_next = S_RD_ADDR;
                            end
                            else
                            begin
                                state_next = S_OFFSET;
                            end
                        end
                        default:
                        begin
                            state_next = S_OFFSET;
                        end
                    endcase
                end
            end

            // linear index of the cursor
            S_BASE:
            begin
                state_next = S_PTR;
            end

            // latch it, then ask for the screen size
            S_PTR:
            begin
                ptr_next   = mac_res;
                mac_req    = '{add: '0, mul_a: rows_reg, mul_b: cols_reg};
                state_next = (ch_reg == CH_TAB) ? S_TAB_LIM : S_PUT;
            end

            S_TAB_LIM:
            begin
                end_next   = mac_res;
                state_next = S_TAB;
            end

            // one space a cycle up to the next tab stop
            S_TAB:
            begin
                if (ptr_reg < end_reg)
                begin
                    cell_wr = '{en: 1'b1, addr: ptr_reg[ADDR_W-1:0], data: {attr, CH_SPACE}};
                end
                ptr_next = ptr_reg + PTR_W'(1);
                col_next = col_reg + COLS_W'(1);
                if (col_reg[2:0] == 3'b111)
                begin
                    state_next = S_WRAP;
                end
            end

            // single cell write, backspace blanks it
            S_PUT:
            begin
                cell_wr = '{en: 1'b1, addr: ptr_reg[ADDR_W-1:0],
                            data: {attr, (ch_reg == CH_BS) ? CH_NUL : ch_reg}};
                if (ch_reg == CH_BS)
                begin
                    state_next = S_OFFSET;
                end
                else
                begin
                    col_next   = col_reg + COLS_W'(1);
                    state_next = S_WRAP;
                end
            end

            // column wrap, then scroll when past the last row
            S_WRAP:
            begin
                if (col_reg >= cols_reg)
                begin
                    col_next = '0;
                    row_wrap = row_reg + ROWS_W'(1);
                end
                if (row_wrap >= rows_reg)
                begin
                    row_next   = rows_reg - ROWS_W'(1);
                    state_next = S_SCR_LIM;
                end
                else
                begin
                    row_next   = row_wrap;
                    state_next = S_OFFSET;
                end
            end

            // cells to move up: cols * (rows - 1)
            S_SCR_LIM:
            begin
                mac_req    = '{add: '0, mul_a: rows_reg - ROWS_W'(1), mul_b: cols_reg};
                state_next = S_SCR_LIM2;
            end

            S_SCR_LIM2:
            begin
                end_next   = mac_res;
                ptr_next   = '0;
                state_next = S_SCR_RD;
            end

            // read the cell one row below
            S_SCR_RD:
            begin
                if (ptr_reg >= end_reg)
                begin
                    end_next   = end_reg + PTR_W'(cols_reg);
                    state_next = S_FILL;
                end
                else
                begin
                    cell_raddr = ADDR_W'(ptr_reg + PTR_W'(cols_reg));
                    state_next = S_SCR_WR;
                end
            end

            S_SCR_WR:
            begin
                cell_wr    = '{en: 1'b1, addr: ptr_reg[ADDR_W-1:0], data: cell_rdata};
                ptr_next   = ptr_reg + PTR_W'(1);
                state_next = S_SCR_RD;
            end

            // screen size for a clear
            S_CLR_LIM:
            begin
                mac_req    = '{add: '0, mul_a: rows_reg, mul_b: cols_reg};
                state_next = S_CLR_LIM2;
            end

            S_CLR_LIM2:
            begin
                end_next   = mac_res;
                ptr_next   = '0;
                state_next = S_FILL;
            end

            // blank cells from ptr up to end
            S_FILL:
            begin
                cell_wr  = '{en: 1'b1, addr: ptr_reg[ADDR_W-1:0], data: {attr, CH_NUL}};
                ptr_next = ptr_reg + PTR_W'(1);
                if (ptr_reg + PTR_W'(1) == end_reg)
                begin
                    state_next = S_OFFSET;
                end
            end

            // read cell: address, memory, capture
            S_RD_ADDR:
            begin
                mac_req    = '{add: PTR_W'(px_reg), mul_a: ROWS_W'(py_reg), mul_b: cols_reg};
                state_next = S_RD_MEM;
            end

            S_RD_MEM:
            begin
                cell_raddr = mac_res[ADDR_W-1:0];
                state_next = S_RD_DATA;
            end

            S_RD_DATA:
            begin
                rc_next    = cell_rdata[7:0];
                ra_next    = cell_rdata[15:8];
                state_next = S_OFFSET;
            end

            // cursor offset for the result
            S_OFFSET:
            begin
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // geometry writes, cursor pulled back into the new screen
        if (cfg.wen)
        begin
            unique case (cfg.index)
                REG_COLS:
                begin
                    cols_next = cols_new;
                    if (col_reg >= cols_new)
                    begin
                        col_next = cols_new - COLS_W'(1);
                    end
                end
                REG_ROWS:
                begin
                    rows_next = rows_new;
                    if (row_reg >= rows_new)
                    begin
                        row_next = rows_new - ROWS_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            col_reg   <= '0;
            row_reg   <= '0;
            fg_reg    <= RESET_FG;
            bg_reg    <= RESET_BG;
            cols_reg  <= RESET_COLS;
            rows_reg  <= RESET_ROWS;
            ptr_reg   <= '0;
            end_reg   <= '0;
            ch_reg    <= '0;
            px_reg    <= '0;
            py_reg    <= '0;
            rc_reg    <= '0;
            ra_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
            cols_reg  <= cols_next;
            rows_reg  <= rows_next;
            ptr_reg   <= ptr_next;
            end_reg   <= end_next;
            ch_reg    <= ch_next;
            px_reg    <= px_next;
            py_reg    <= py_next;
            rc_reg    <= rc_next;
            ra_reg    <= ra_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/tcw_checker.sv -----
`default_nettype none
`include "text_console_writer_defines.svh"

// port-level checks for the console writer
module tcw_checker
    import tcw_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [47:0]          m_tdata,
    input wire logic                 cfg_wen,
    input wire logic [CFG_IDX_W-1:0] cfg_index,
    input wire logic [COLS_W-1:0]    cfg_wdata
);

    logic [COLS_W-1:0] cols_seen_reg, cols_seen_next;
    logic [PTR_W-1:0]  off_calc;

    // track the column count from the config port
    always_comb
    begin
        cols_seen_next = cols_seen_reg;
        if (cfg_wen && cfg_index == REG_COLS)
        begin
            cols_seen_next = clamp_cols(cfg_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_seen_reg <= RESET_COLS;
        end
        else
        begin
            cols_seen_reg <= cols_seen_next;
        end
    end

    assign off_calc = PTR_W'(m_tdata[6:0]) + PTR_W'(m_tdata[11:7]) * PTR_W'(cols_seen_reg);

    `TCW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TCW_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `TCW_ASSERT_IMPL(a_offset_match, m_tvalid, m_tdata[23:12] == off_calc[ADDR_W-1:0])
    `TCW_ASSERT_IMPL(a_cursor_in_row, m_tvalid, {1'b0, m_tdata[6:0]} < cols_seen_reg)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
);

`default_nettype wire

// ----- tb/tb_text_console_writer.sv -----
`timescale 1ns / 100ps

module tb_text_console_writer;
    import tcw_pkg::*;

    // command codes with no function behind them
    localparam logic [2:0] FN_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] FN_UNUSED_LAST  = 3'd7;

    // register indexes that select nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int DIR_N          = 25;
    localparam int PHASE_N        = 9;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int HOLD_AT_ITEM   = 300;
    localparam int PAUSE_AT_ITEM  = 480;

    localparam res_t NO_RES = '0;

    typedef struct packed {
        cmd_t c;
        logic typed;
        res_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic [2:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic                 cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COLS_W-1:0]    cfg_wdata = '0;

    // shadow screen and console state
    logic [15:0] screen_cells [0:STORE_CELLS-1];
    int          scr_cols;
    int          scr_rows;
    int          csr_col;
    int          csr_row;
    logic [3:0]  pen_fg;
    logic [3:0]  pen_bg;

    res_t pending_reports [$];

    int fail_count     = 0;
    int reports_seen   = 0;
    int cmds_directed  = 0;
    int cmds_random    = 0;
    int geometries     = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int hold_reqs      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    res_t rx_want;
    res_t rx_got;

    // directed commands, expected report typed in where it is obvious
    dir_row_t directed_tbl [0:DIR_N-1] = '{
        // read origin straight after reset
        {FN_READ, 8'h00, 7'd0, 5'd0, 4'h0, 4'h0,
         1'b1, 7'd0, 5'd0, 12'd0, 4'h7, 4'h0, 8'h00, 8'h07},
        // unused code with every field at its top value
        {FN_UNUSED_LAST, 8'hFF, 7'd127, 5'd31, 4'hF, 4'hF,
         1'b1, 7'd0, 5'd0, 12'd0, 4'h7, 4'h0, 8'h00, 8'h00},
        // read outside the screen
        {FN_READ, 8'h00, 7'd127, 5'd31, 4'h0, 4'h0,
         1'b1, 7'd0, 5'd0, 12'd0, 4'h7, 4'h0, 8'h00, 8'h00},
        // null character ignored
        {FN_PUT, CH_NUL, 7'd0, 5'd0, 4'h0, 4'h0,
         1'b1, 7'd0, 5'd0, 12'd0, 4'h7, 4'h0, 8'h00, 8'h00},
        // backspace at the origin
        {FN_PUT, CH_BS, 7'd0, 5'd0, 4'h0, 4'h0,
         1'b1, 7'd0, 5'd0, 12'd0, 4'h7, 4'h0, 8'h00, 8'h00},
        {FN_COLOUR, 8'h00, 7'd0, 5'd0, 4'hF, 4'hF,
         1'b1, 7'd0, 5'd0, 12'd0, 4'hF, 4'hF, 8'h00, 8'h00},
        {FN_PUT, 8'h41, 7'd0, 5'd0, 4'h0, 4'h0, 1'b0, NO_RES},
        {FN_PUT, 8'hFF, 7'd0, 5'd0, 4'h0, 4'h0, 1'b0, NO_RES},
        {FN_PUT, 8'h80, 7'd0, 5'd0, 4'h0, 4'h0, 1'b0, NO_RES},
        {FN_PUT, CH_TAB, 7'd0, 5'd0, 4'h0, 4'h0, 1'b0, NO_RES},
        {FN_READ, 8'h00, 7'd0, 5'd0, 4'h0, 4'h0, 1'b0, NO_RES},
        // last cell, then a character that wraps and scrolls
        {FN_CURSOR, 8'h00, 7'd79, 5'd24, 4'h0, 4'h0, 1'b0, NO_RES},
        {FN_PUT, 8'h5A, 7'd0, 5'd0, 4'h0, 4'h0, 1'b0, NO_RES},
        // backspace from column zero to the previous row end
        {FN_PUT, CH_BS, 7'd0, 5'd0, 4'h0, 4'h0, 1'b0, NO_RES},
        {FN_PUT, CH_LF, 7'd0, 5'd0, 4'h0, 4'h0, 1'b0, NO_RES},
        // cursor outside the screen is ignored
        {FN_CURSOR, 8'h00, 7'd127, 5'd31, 4'h0, 4'h0, 1'b0, NO_RES},
        {FN_COLOUR, 8'h00, 7'd0, 5'd0, 4'h0, 4'hA, 1'b0, NO_RES},
        {FN_READ, 8'h00, 7'd79, 5'd24, 4'h0, 4'h0, 1'b0, NO_RES},
        {FN_CLEAR, 8'h00, 7'd0, 5'd0, 4'h0, 4'h0,
         1'b1, 7'd0, 5'd0, 12'd0, 4'h0, 4'hA, 8'h00, 8'h00},
        {FN_READ, 8'h00, 7'd5, 5'd5, 4'h0, 4'h0,
         1'b1, 7'd0, 5'd0, 12'd0, 4'h0, 4'hA, 8'h00, 8'hA0},
        // tab that runs into the row end
        {FN_CURSOR, 8'h00, 7'd77, 5'd3, 4'h0, 4'h0, 1'b0, NO_RES},
        {FN_PUT, CH_TAB, 7'd0, 5'd0, 4'h0, 4'h0, 1'b0, NO_RES},
        {FN_READ, 8'h00, 7'd42, 5'd10, 4'h0, 4'h0, 1'b0, NO_RES},
        {FN_PUT, 8'h55, 7'd0, 5'd0, 4'h0, 4'h0, 1'b0, NO_RES},
        {FN_PUT, 8'hAA, 7'd0, 5'd0, 4'h0, 4'h0, 1'b0, NO_RES}
    };

    // screen geometries for the random part, extremes among them
    int phase_cols [0:PHASE_N-1]  = '{13, 8, 0, 255, 17, 128, 1, 20, 5};
    int phase_rows [0:PHASE_N-1]  = '{4, 2, 0, 63, 3, 1, 32, 6, 9};
    int phase_items [0:PHASE_N-1] = '{110, 80, 40, 40, 100, 40, 50, 120, 70};

    text_console_writer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // shadow state after reset
    function automatic void console_reset();
        int i;
        for (i = 0; i < STORE_CELLS; i++)
            screen_cells[i] = 16'h0700;
        scr_cols = 80;
        scr_rows = 25;
        csr_col  = 0;
        csr_row  = 0;
        pen_fg   = 4'h7;
        pen_bg   = 4'h0;
    endfunction

    // register write: limits clamped, cursor pulled into the new screen
    function automatic void console_resize(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        int v;
        if (idx == REG_COLS)
        begin
            v = val;
            scr_cols = (v == 0) ? 1 : ((v > MAX_COLS) ? MAX_COLS : v);
        end
        else if (idx == REG_ROWS)
        begin
            v = val & 8'h3F;
            scr_rows = (v == 0) ? 1 : ((v > MAX_ROWS) ? MAX_ROWS : v);
        end
        else
            return;
        if (csr_col >= scr_cols)
            csr_col = scr_cols - 1;
        if (csr_row >= scr_rows)
            csr_row = scr_rows - 1;
    endfunction

    function automatic void cell_write(int idx, logic [7:0] ch);
        if (idx < scr_cols * scr_rows)
            screen_cells[idx] = {pen_bg, pen_fg, ch};
    endfunction

    // row overflow: shift rows up, blank the bottom row
    function automatic void scroll_up();
        int i;
        if (csr_row < scr_rows)
            return;
        csr_row = scr_rows - 1;
        for (i = 0; i < scr_cols * (scr_rows - 1); i++)
            screen_cells[i] = screen_cells[i + scr_cols];
        for (i = scr_cols * (scr_rows - 1); i < scr_cols * scr_rows; i++)
            screen_cells[i] = {pen_bg, pen_fg, 8'h00};
    endfunction

    function automatic void console_putc(logic [7:0] ch);
        int base;
        if (ch == CH_NUL)
            return;
        if (ch == CH_BS)
        begin
            if (csr_col == 0 && csr_row == 0)
                return;
            if (csr_col != 0)
                csr_col--;
            else
            begin
                csr_col = scr_cols - 1;
                csr_row--;
            end
            cell_write(csr_col + csr_row * scr_cols, 8'h00);
            return;
        end
        base = csr_col + csr_row * scr_cols;
        if (ch == CH_LF)
            csr_col = scr_cols;
        else if (ch == CH_TAB)
        begin
            do
            begin
                cell_write(base, CH_SPACE);
                base++;
                csr_col++;
            end
            while ((csr_col % 8) != 0);
        end
        else
        begin
            cell_write(base, ch);
            csr_col++;
        end
        // wrap at the column limit
        if (csr_col >= scr_cols)
        begin
            csr_col = 0;
            csr_row++;
        end
        scroll_up();
    endfunction

    // apply one command to the shadow state and build its report
    function automatic res_t console_step(cmd_t c);
        res_t r;
        int   i;
        r = '0;
        case (c.func)
            FN_PUT:
                console_putc(c.char_code);
            FN_CURSOR:
            begin
                if (c.pos_x < scr_cols)
                    csr_col = c.pos_x;
                if (c.pos_y < scr_rows)
                    csr_row = c.pos_y;
            end
            FN_CLEAR:
            begin
                for (i = 0; i < scr_cols * scr_rows; i++)
                    screen_cells[i] = {pen_bg, pen_fg, 8'h00};
                csr_col = 0;
                csr_row = 0;
            end
            FN_COLOUR:
            begin
                pen_fg = c.fg_in;
                pen_bg = c.bg_in;
            end
            FN_READ:
            begin
                if (c.pos_x < scr_cols && c.pos_y < scr_rows)
                begin
                    i = c.pos_x + c.pos_y * scr_cols;
                    r.cell_char = screen_cells[i][7:0];
                    r.cell_attr = screen_cells[i][15:8];
                end
            end
            default:
            begin
            end
        endcase
        r.cursor_x      = 7'(csr_col);
        r.cursor_y      = 5'(csr_row);
        r.cursor_offset = 12'(csr_col + csr_row * scr_cols);
        r.fg_out        = pen_fg;
        r.bg_out        = pen_bg;
        return r;
    endfunction

    // random command, mostly characters, positions mostly on screen
    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        int   sub;
        c.char_code = 8'($urandom_range(255));
        c.pos_x     = 7'($urandom_range(127));
        c.pos_y     = 5'($urandom_range(31));
        c.fg_in     = 4'($urandom_range(15));
        c.bg_in     = 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 52)
        begin
            c.func = FN_PUT;
            sub = $urandom_range(99);
            if (sub < 10)
                c.char_code = CH_LF;
            else if (sub < 17)
                c.char_code = CH_TAB;
            else if (sub < 25)
                c.char_code = CH_BS;
            else if (sub < 29)
                c.char_code = CH_NUL;
        end
        else if (pick < 64)
            c.func = FN_CURSOR;
        else if (pick < 67)
            c.func = FN_CLEAR;
        else if (pick < 75)
            c.func = FN_COLOUR;
        else if (pick < 96)
            c.func = FN_READ;
        else
            c.func = 3'($urandom_range(FN_UNUSED_LAST, FN_UNUSED_FIRST));
        if (c.func == FN_CURSOR || c.func == FN_READ)
        begin
            if ($urandom_range(99) < 80)
                c.pos_x = 7'($urandom_range(scr_cols - 1));
            if ($urandom_range(99) < 80)
                c.pos_y = 5'($urandom_range(scr_rows - 1));
        end
        return c;
    endfunction

    // offer one command beat and record its expected report once taken
    task automatic offer_command(cmd_t c, logic typed, res_t want);
        int   gap;
        res_t r;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, c.bg_in, c.fg_in, c.pos_y, c.pos_x, c.char_code};
        s_tuser  <= c.func;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = console_step(c);
        pending_reports.push_back(typed ? want : r);
    endtask

    // stop offering and let every report come out
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [COLS_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        console_resize(idx, val);
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void field_check(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // result side: check each report beat, pace m_tready
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_got.cursor_x      = m_tdata[6:0];
            rx_got.cursor_y      = m_tdata[11:7];
            rx_got.cursor_offset = m_tdata[23:12];
            rx_got.fg_out        = m_tdata[27:24];
            rx_got.bg_out        = m_tdata[31:28];
            rx_got.cell_char     = m_tdata[39:32];
            rx_got.cell_attr     = m_tdata[47:40];
            if (pending_reports.size() == 0)
            begin
                $error("report beat with nothing expected: 0x%012h", m_tdata);
                fail_count++;
            end
            else
            begin
                rx_want = pending_reports.pop_front();
                reports_seen++;
                field_check("cursor_x", rx_want.cursor_x, rx_got.cursor_x);
                field_check("cursor_y", rx_want.cursor_y, rx_got.cursor_y);
                field_check("cursor_offset", rx_want.cursor_offset, rx_got.cursor_offset);
                field_check("fg_out", rx_want.fg_out, rx_got.fg_out);
                field_check("bg_out", rx_want.bg_out, rx_got.bg_out);
                field_check("cell_char", rx_want.cell_char, rx_got.cell_char);
                field_check("cell_attr", rx_want.cell_attr, rx_got.cell_attr);
            end
        end
        // long hold-off on request, otherwise random stalls
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_reqs != hold_seen)
        begin
            hold_seen = hold_reqs;
            hold_left = RX_HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // stimulus
    initial
    begin
        int   i;
        int   p;
        int   j;
        cmd_t c;
        console_reset();
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at the reset geometry
        for (i = 0; i < DIR_N; i++)
        begin
            offer_command(directed_tbl[i].c, directed_tbl[i].typed, directed_tbl[i].want);
            cmds_directed++;
        end

        // random part, one geometry per phase
        for (p = 0; p < PHASE_N; p++)
        begin
            drain_reports();
            reg_write(REG_COLS, COLS_W'(phase_cols[p]));
            reg_write(REG_ROWS, COLS_W'(phase_rows[p]));
            if (p == 4)
            begin
                reg_write(REG_SPARE_A, COLS_W'($urandom_range(255)));
                reg_write(REG_SPARE_B, COLS_W'($urandom_range(255)));
            end
            geometries++;
            for (j = 0; j < phase_items[p]; j++)
            begin
                // receiver sparse, then sender sparse, then no gaps
                if (cmds_random < 217)
                begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 74;
                end
                else if (cmds_random < 434)
                begin
                    tx_idle_pct = 74;
                    rx_idle_pct = 20;
                end
                else
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                if (cmds_random == HOLD_AT_ITEM)
                    hold_reqs++;
                if (cmds_random == PAUSE_AT_ITEM)
                    drain_reports();
                c = random_cmd();
                offer_command(c, 1'b0, NO_RES);
                cmds_random++;
            end
        end

        drain_reports();
        $display("summary: %0d commands (%0d directed, %0d random) over %0d screen sizes",
                 cmds_directed + cmds_random, cmds_directed, cmds_random, geometries);
        $display("summary: %0d reports checked, %0d failures", reports_seen, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
